// ===== rtl/ues_pkg.sv =====
`timescale 1ns / 1ps

package ues_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);
    localparam int MaxRes = 3;
    localparam int ResCntW = $clog2(MaxRes + 1);

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THR  = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam logic [15:0] MISC_LO   = 16'h2600;
    localparam logic [15:0] MISC_HI   = 16'h27BF;
    localparam logic [15:0] TECH_LO   = 16'h2300;
    localparam logic [15:0] TECH_HI   = 16'h23FF;
    localparam logic [15:0] STAR_LO   = 16'h2B50;
    localparam logic [15:0] STAR_HI   = 16'h2B55;
    localparam logic [15:0] CJK_LO    = 16'h3297;
    localparam logic [15:0] CJK_HI    = 16'h3299;
    localparam logic [15:0] ZWJ_CP    = 16'h200D;
    localparam logic [15:0] VSEL_LO   = 16'hFE00;
    localparam logic [15:0] VSEL_HI   = 16'hFE0F;
    localparam logic [15:0] KEYCAP_CP = 16'h20E3;

    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       last;
    } res_item_t;

    typedef struct packed {
        logic                        vld;
        logic [ResCntW-1:0]          cnt;
        res_item_t [MaxRes-1:0]      item;
    } res_batch_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80) len = LEN_ONE;
        else if (b < 8'hE0) len = LEN_TWO;
        else if (b < 8'hF0) len = LEN_THR;
        else len = LEN_FOUR;
        return len;
    endfunction

    function automatic logic emoji_range_hit(input logic [15:0] cp);
        logic hit;
        hit = ((cp >= MISC_LO) && (cp <= MISC_HI))
            || ((cp >= TECH_LO) && (cp <= TECH_HI))
            || ((cp >= STAR_LO) && (cp <= STAR_HI))
            || ((cp >= CJK_LO) && (cp <= CJK_HI))
            || (cp == ZWJ_CP)
            || ((cp >= VSEL_LO) && (cp <= VSEL_HI))
            || (cp == KEYCAP_CP);
        return hit;
    endfunction

endpackage

// ===== rtl/ues_decode.sv =====
`timescale 1ns / 1ps

module ues_decode import ues_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output res_batch_t batch,
    input  logic       take
);

    logic       stg_vld_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_eot_reg;
    logic       load;

    logic [2:0] exp_reg;
    logic [2:0] exp_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [7:0] held0_reg;
    logic [7:0] held0_next;
    logic [7:0] held1_reg;
    logic [7:0] held1_next;

    logic [2:0]          len;
    logic [2:0]          cnt1;
    logic [15:0]         cp;
    logic [ResCntW-1:0]  n;
    res_item_t [MaxRes-1:0] item;

    assign in_stall = stg_vld_reg && !take;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
        end
        else if (load || take)
        begin
            stg_vld_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_byte_reg <= in_byte;
            stg_eot_reg  <= end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= LEN_NONE;
            cnt_reg <= 2'd0;
        end
        else if (take)
        begin
            exp_reg <= exp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    always_comb
    begin
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        n          = '0;
        item       = '0;
        len        = lead_len(stg_byte_reg);
        cnt1       = {1'b0, cnt_reg} + 3'd1;
        cp         = {held0_reg[3:0], held1_reg[5:0], stg_byte_reg[5:0]};

        if (exp_reg == LEN_NONE)
        begin
            if (len == LEN_ONE)
            begin
                item[0] = '{data: stg_byte_reg, vld: 1'b1, last: 1'b0};
                n       = ResCntW'(1);
            end
            else
            begin
                exp_next   = len;
                cnt_next   = 2'd1;
                held0_next = stg_byte_reg;
            end
        end
        else if (cnt1 < exp_reg)
        begin
            if ((cnt1 < 3'd3) && (exp_reg != LEN_FOUR))
            begin
                held1_next = stg_byte_reg;
            end
            cnt_next = cnt1[1:0];
        end
        else
        begin
            if (exp_reg == LEN_TWO)
            begin
                item[0] = '{data: held0_reg, vld: 1'b1, last: 1'b0};
                item[1] = '{data: stg_byte_reg, vld: 1'b1, last: 1'b0};
                n       = ResCntW'(2);
            end
            else if ((exp_reg == LEN_THR) && !emoji_range_hit(cp))
            begin
                item[0] = '{data: held0_reg, vld: 1'b1, last: 1'b0};
                item[1] = '{data: held1_reg, vld: 1'b1, last: 1'b0};
                item[2] = '{data: stg_byte_reg, vld: 1'b1, last: 1'b0};
                n       = ResCntW'(3);
            end
            exp_next = LEN_NONE;
            cnt_next = 2'd0;
        end

        if (stg_eot_reg)
        begin
            // flush a cut sequence: nothing was emitted while it was open
            if ((exp_next != LEN_NONE) && (exp_next != LEN_FOUR))
            begin
                item[0] = '{data: held0_next, vld: 1'b1, last: 1'b0};
                item[1] = '{data: held1_next, vld: 1'b1, last: 1'b0};
                n       = ResCntW'(cnt_next);
            end
            exp_next = LEN_NONE;
            cnt_next = 2'd0;
            unique case (n)
                ResCntW'(0):
                begin
                    item[0] = '{data: 8'd0, vld: 1'b0, last: 1'b1};
                    n       = ResCntW'(1);
                end
                ResCntW'(1): item[0].last = 1'b1;
                ResCntW'(2): item[1].last = 1'b1;
                default:     item[2].last = 1'b1;
            endcase
        end
    end

    assign batch.vld  = stg_vld_reg;
    assign batch.cnt  = n;
    assign batch.item = item;

`ifndef NO_ASSERTIONS
    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        exp_reg != LEN_ONE && exp_reg <= LEN_FOUR)
        else $error("open sequence length out of range");

    a_cnt_vs_len: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg == LEN_NONE) == (cnt_reg == 2'd0)
        && (exp_reg == LEN_NONE || {1'b0, cnt_reg} < exp_reg))
        else $error("received count inconsistent with sequence length");

    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        take && stg_eot_reg |-> n != '0 ##1 exp_reg == LEN_NONE)
        else $error("end of text left a sequence open or no result");
`endif

endmodule

// ===== rtl/ues_outq.sv =====
`timescale 1ns / 1ps

module ues_outq import ues_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  res_batch_t batch,
    output logic       take,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_out
);

    res_item_t        q_reg [QDepth];
    logic [QPtrW-1:0] head_reg;
    logic [QPtrW-1:0] tail_reg;
    logic [QCntW-1:0] cnt_reg;
    logic [QCntW-1:0] cnt_next;
    logic             pop;
    logic [QCntW:0]   fill;

    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign fill      = {1'b0, cnt_reg} - {{QCntW{1'b0}}, pop}
                     + (QCntW + 1)'(batch.cnt);
    assign take      = batch.vld && (fill <= (QCntW + 1)'(QDepth));
    assign cnt_next  = cnt_reg - QCntW'(pop) + (take ? QCntW'(batch.cnt) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (take)
            begin
                tail_reg <= tail_reg + QPtrW'(batch.cnt);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MaxRes; k++)
        begin
            if (take && (k < int'(batch.cnt)))
            begin
                q_reg[tail_reg + QPtrW'(k)] <= batch.item[k];
            end
        end
    end

    assign out_byte   = q_reg[head_reg].data;
    assign byte_valid = q_reg[head_reg].vld;
    assign last_out   = q_reg[head_reg].last;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCntW'(QDepth))
        else $error("output queue overflow");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> cnt_reg >= $past(cnt_reg))
        else $error("queued request lost while stalled");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != QCntW'(QDepth) |-> (tail_reg - head_reg) == QPtrW'(cnt_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/utf8_emoji_strip_filter_top.sv =====
`timescale 1ns / 1ps

// Strips emoji from a UTF-8 byte stream. One byte is taken per cycle, while
// in_stall is low, into an input register; the decode logic groups it with
// the open sequence (length from the lead byte only, continuation bytes
// unchecked), drops 4-byte sequences and 3-byte sequences whose code point
// lies in the emoji ranges, and pushes up to three kept bytes into a 4-entry
// output queue that drains one request per cycle while out_stall is low. A
// byte marked end_of_text always yields a request with last_out set; the
// bytes received so far of a cut 2- or 3-byte sequence are flushed as is, and
// a bare marker with byte_valid low is sent when nothing else is left. Bytes
// pass the input register, then the output queue. The input stalls only when
// the queue has no room for the results of the registered byte, so with the
// output draining every cycle the block sustains one byte per cycle.

module utf8_emoji_strip_filter_top import ues_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_out
);

    res_batch_t batch;
    logic       take;

    ues_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .batch       (batch),
        .take        (take)
    );

    ues_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last_out   (last_out)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ues_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       vld;
        logic       last;
    } kept_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_out;

    kept_t      kept_q[$];
    logic [2:0] seq_len = LEN_NONE;
    logic [1:0] seq_got = 2'd0;
    logic [7:0] seq_hold[2];
    logic       idle_on = 1'b1;
    int         err_cnt = 0;
    int         sent = 0;

    utf8_emoji_strip_filter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_out    (last_out)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        out_stall <= idle_on && ($urandom_range(0, 99) < 14);

    function automatic logic emoji_cp(input logic [15:0] cp);
        logic hit;
        hit = 1'b0;
        if (cp >= MISC_LO && cp <= MISC_HI) hit = 1'b1;
        if (cp >= TECH_LO && cp <= TECH_HI) hit = 1'b1;
        if (cp >= STAR_LO && cp <= STAR_HI) hit = 1'b1;
        if (cp >= CJK_LO && cp <= CJK_HI) hit = 1'b1;
        if (cp >= VSEL_LO && cp <= VSEL_HI) hit = 1'b1;
        if (cp == ZWJ_CP || cp == KEYCAP_CP) hit = 1'b1;
        return hit;
    endfunction

    task automatic push_kept(input logic [7:0] b, input logic v);
        kept_t k;
        k.data = b;
        k.vld  = v;
        k.last = 1'b0;
        kept_q.push_back(k);
    endtask

    task automatic predict_kept(input logic [7:0] b, input logic eot);
        int         n;
        int         i;
        logic [2:0] cnt;
        logic [15:0] cp;
        n = 0;
        if (seq_len == LEN_NONE)
        begin
            if (b < 8'h80)
            begin
                if (!emoji_cp({8'h00, b}))
                begin
                    push_kept(b, 1'b1);
                    n++;
                end
            end
            else
            begin
                if (b < 8'hE0) seq_len = LEN_TWO;
                else if (b < 8'hF0) seq_len = LEN_THR;
                else seq_len = LEN_FOUR;
                seq_got = 2'd1;
                seq_hold[0] = b;
            end
        end
        else
        begin
            cnt = {1'b0, seq_got} + 3'd1;
            if (cnt < seq_len)
            begin
                if (cnt < 3'd3 && seq_len != LEN_FOUR)
                    seq_hold[cnt - 3'd1] = b;
                seq_got = cnt[1:0];
            end
            else
            begin
                if (seq_len == LEN_TWO)
                begin
                    cp = {5'd0, seq_hold[0][4:0], b[5:0]};
                    if (!emoji_cp(cp))
                    begin
                        push_kept(seq_hold[0], 1'b1);
                        push_kept(b, 1'b1);
                        n += 2;
                    end
                end
                else if (seq_len == LEN_THR)
                begin
                    cp = {seq_hold[0][3:0], seq_hold[1][5:0], b[5:0]};
                    if (!emoji_cp(cp))
                    begin
                        push_kept(seq_hold[0], 1'b1);
                        push_kept(seq_hold[1], 1'b1);
                        push_kept(b, 1'b1);
                        n += 3;
                    end
                end
                seq_len = LEN_NONE;
                seq_got = 2'd0;
            end
        end
        if (eot)
        begin
            if (seq_len != LEN_NONE && seq_len != LEN_FOUR)
            begin
                for (i = 0; i < seq_got && i < 2; i++)
                begin
                    push_kept(seq_hold[i], 1'b1);
                    n++;
                end
            end
            seq_len = LEN_NONE;
            seq_got = 2'd0;
            if (n == 0)
                push_kept(8'h00, 1'b0);
            kept_q[kept_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s: got %02h, want %02h", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin : check_out
        kept_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (kept_q.size() == 0)
            begin
                report_mismatch("request with nothing pending", out_byte, 8'h00);
            end
            else
            begin
                want = kept_q.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (byte_valid !== want.vld)
                    report_mismatch("byte_valid", {7'd0, byte_valid}, {7'd0, want.vld});
                if (last_out !== want.last)
                    report_mismatch("last_out", {7'd0, last_out}, {7'd0, want.last});
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (idle_on && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_kept(b, eot);
        sent++;
    endtask

    task automatic hold_off();
        in_valid <= 1'b0;
        while (kept_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        // stray continuation opens a two-byte sequence
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_emoji_drop();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h97, 1'b0);
        send_byte(8'hBF, 1'b0);
        // dropped at end of text: bare end marker
        send_byte(8'hEF, 1'b0);
        send_byte(8'hB8, 1'b0);
        send_byte(8'h8F, 1'b1);
    endtask

    task automatic test_four_byte();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_cut_sequences();
        send_byte(8'hC2, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hFF, 1'b1);
        hold_off();
    endtask

    task automatic test_random_text();
        int          txt;
        int          n_chars;
        int          i;
        int          kind;
        int          cut;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] cp;
        logic [7:0]  chr[$];
        logic [7:0]  text[$];
        txt = 0;
        while (sent < 410)
        begin
            idle_on = !(txt >= 6 && txt < 11);
            text.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                n_chars = $urandom_range(1, 12);
                repeat (n_chars) text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                n_chars = $urandom_range(1, 10);
                for (i = 0; i < n_chars; i++)
                begin
                    chr.delete();
                    kind = $urandom_range(0, 99);
                    if (kind < 30)
                    begin
                        chr.push_back(8'($urandom_range(0, 127)));
                    end
                    else if (kind < 45)
                    begin
                        chr.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                        chr.push_back(8'($urandom_range(0, 255)));
                    end
                    else if (kind < 53)
                    begin
                        chr.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        chr.push_back(8'($urandom_range(0, 255)));
                    end
                    else if (kind < 68)
                    begin
                        chr.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                        repeat (2) chr.push_back(8'($urandom_range(0, 255)));
                    end
                    else if (kind < 90)
                    begin
                        case ($urandom_range(0, 6))
                            0: {lo, hi} = {MISC_LO, MISC_HI};
                            1: {lo, hi} = {TECH_LO, TECH_HI};
                            2: {lo, hi} = {STAR_LO, STAR_HI};
                            3: {lo, hi} = {CJK_LO, CJK_HI};
                            4: {lo, hi} = {ZWJ_CP, ZWJ_CP};
                            5: {lo, hi} = {VSEL_LO, VSEL_HI};
                            default: {lo, hi} = {KEYCAP_CP, KEYCAP_CP};
                        endcase
                        case ($urandom_range(0, 4))
                            0: cp = lo - 16'd1;
                            1: cp = hi + 16'd1;
                            default: cp = lo + 16'($urandom_range(0, hi - lo));
                        endcase
                        chr.push_back({4'hE, cp[15:12]});
                        chr.push_back({2'($urandom_range(0, 3)), cp[11:6]});
                        chr.push_back({2'($urandom_range(0, 3)), cp[5:0]});
                    end
                    else
                    begin
                        chr.push_back(8'($urandom_range(8'hF0, 8'hFF)));
                        repeat (3) chr.push_back(8'($urandom_range(0, 255)));
                    end
                    // drop a tail to break the sequence
                    if (chr.size() > 1 && (($urandom_range(0, 19) == 0)
                            || (i == n_chars - 1 && $urandom_range(0, 3) == 0)))
                    begin
                        cut = $urandom_range(1, chr.size() - 1);
                        repeat (cut) chr.delete(chr.size() - 1);
                    end
                    foreach (chr[k]) text.push_back(chr[k]);
                end
            end
            foreach (text[k]) send_byte(text[k], k == text.size() - 1);
            if (txt % 6 == 5) hold_off();
            txt++;
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_emoji_drop();
        test_four_byte();
        test_cut_sequences();
        test_random_text();
        hold_off();
        if (err_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ues_pkg.sv
rtl/ues_decode.sv
rtl/ues_outq.sv
rtl/utf8_emoji_strip_filter_top.sv
verif/testbench.sv
